/* design/mlfq_pkg.sv */
// Package with shared types and constants of the feedback-queue scheduler.
package mlfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int NUM_LEVELS_DEF  = 3;
    localparam logic [7:0]  QUANTUM_RESET = 8'd50;
    localparam logic [15:0] SLICE_RESET   = 16'd200;

    // Operation codes.
    localparam logic [1:0] OP_ARRIVE   = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_BOOST    = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_QUEUED   = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_RAN      = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;
    localparam logic [2:0] ST_BOOSTED  = 3'd5;

    // Configuration register indexes.
    localparam logic [0:0] REG_QUANTUM = 1'b0;
    localparam logic [0:0] REG_SLICE   = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  task_id;
        logic [15:0] task_length;
        logic [6:0]  io_percent;
        logic [6:0]  io_chance;
        logic [7:0]  io_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_task_id;
        logic [7:0] run_amount;
        logic [1:0] new_level;
    } t_out_item;

    // Task record held in the task memory.
    typedef struct packed {
        logic [15:0] total;
        logic [15:0] done_time;
        logic [6:0]  io_percent;
        logic [1:0]  level;
        logic [15:0] slice_left;
        logic [7:0]  run_limit;
    } t_task_rec;

endpackage

/* design/multilevel_feedback_queue_scheduler.sv */
// Top level of the three-level feedback-queue task scheduler.
//
// Usage: items enter on the input channel (i_in_valid, o_in_stall, i_in_item) and
// each arrive, dispatch or boost gives one result on the output channel
// (o_out_valid, i_out_stall, o_out_item). Operation code 3 is taken and dropped.
// Task records sit in a 256-entry memory and the level queues in one memory of
// NUM_LEVELS*QUEUE_DEPTH entries; both have a registered read port.
// Steps: an arrive goes through decode and output; a dispatch through queue read,
// record read, compute and write back, then output. A boost repeats for each task
// moved: queue read, record read, wait, record write-back.
// One item is worked on at a time; the next transfer is taken in the idle state
// after the result has been loaded, so a new item is not taken before the last one
// is through. While a result waits under stall, the input stalls.
// Reset is synchronous: queues become empty, all slots inactive, quantum 50,
// time slice 200. No clearing pass is needed. A stalled result holds steady.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken any cycle.
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int AW = $clog2(NUM_LEVELS * QUEUE_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DECODE= 9'b000000010,
        S_QREAD = 9'b000000100,
        S_TREAD = 9'b000001000,
        S_CALC  = 9'b000010000,
        S_BQREAD= 9'b000100000,
        S_BTWAIT= 9'b001000000,
        S_BMOVE = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [7:0]  r_quantum;
    logic [15:0] r_slice;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
            r_slice   <= SLICE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_QUANTUM) r_quantum <= i_cfg_data[7:0];
            else                            r_slice   <= i_cfg_data;
        end
    end

    // Queue bookkeeping and slot flags.
    logic [NUM_LEVELS-1:0][QW-1:0] r_heads;
    logic [NUM_LEVELS-1:0][CW-1:0] r_counts;
    logic [255:0]                  r_active;

    // Memories.
    logic [7:0]  r_qmem [NUM_LEVELS*QUEUE_DEPTH];
    t_task_rec   r_tmem [256];
    logic [7:0]  r_qrd;
    t_task_rec   r_trd;

    logic        q_we, t_we;
    logic [AW-1:0] q_waddr, q_raddr;
    logic [7:0]  q_wdata;
    logic [7:0]  t_waddr, t_raddr;
    t_task_rec   t_wdata;

    always_ff @(posedge i_clk) begin
        if (q_we) r_qmem[q_waddr] <= q_wdata;
        r_qrd <= r_qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) r_tmem[t_waddr] <= t_wdata;
        r_trd <= r_tmem[t_raddr];
    end

    // Item registers.
    t_in_item  r_item;
    t_out_item r_res;
    logic      r_out_valid;
    logic [LW-1:0] r_lv;
    logic [7:0]    r_id;

    function automatic logic [AW-1:0] qaddr(input logic [LW-1:0] lv, input logic [QW-1:0] ix);
        qaddr = AW'(lv) * AW'(QUEUE_DEPTH) + AW'(ix);
    endfunction

    function automatic logic [QW-1:0] tail_of(input logic [QW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(c);
        if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
        tail_of = s[QW-1:0];
    endfunction

    function automatic logic [QW-1:0] inc_ix(input logic [QW-1:0] h);
        logic [QW:0] s;
        s = (QW+1)'(h) + 1'b1;
        if (s >= (QW+1)'(QUEUE_DEPTH)) s = '0;
        inc_ix = s[QW-1:0];
    endfunction

    // First non-empty level.
    logic          any_q;
    logic [LW-1:0] first_lv;
    always_comb begin
        any_q    = 1'b0;
        first_lv = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_counts[l] != '0) begin
                any_q    = 1'b1;
                first_lv = LW'(l);
            end
        end
    end

    // Boost: next level with a task to move.
    logic          bmore;
    logic [LW-1:0] blv_next;
    always_comb begin
        bmore    = 1'b0;
        blv_next = '0;
        for (int l = NUM_LEVELS - 1; l >= 1; l--) begin
            if (r_counts[l] != '0) begin
                bmore    = 1'b1;
                blv_next = LW'(l);
            end
        end
    end

    logic full0;
    assign full0 = (r_counts[0] == CW'(QUEUE_DEPTH));

    // Dispatch arithmetic on the record just read.
    logic [15:0] left, run16, slice_new;
    logic [7:0]  cap;
    logic        complete, io_hit;
    logic [LW-1:0] tgt_up, tgt;
    always_comb begin
        left      = (r_trd.total > r_trd.done_time) ? r_trd.total - r_trd.done_time : 16'd0;
        io_hit    = (r_item.io_chance <= r_trd.io_percent) && (r_item.io_time <= r_trd.run_limit);
        cap       = io_hit ? r_item.io_time : r_trd.run_limit;
        complete  = left <= {8'd0, cap};
        run16     = complete ? left : {8'd0, cap};
        slice_new = (r_trd.slice_left > run16) ? r_trd.slice_left - run16 : 16'd0;
        tgt_up    = (32'(r_lv) + 1 < NUM_LEVELS) ? r_lv + 1'b1 : r_lv;
        tgt       = (slice_new == '0) ? tgt_up : r_lv;
        if (r_counts[tgt] == CW'(QUEUE_DEPTH)) tgt = r_lv;
    end

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_res;

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = r_id;
        case (r_state)
            S_IDLE: if (in_xfer) n_state = S_DECODE;
            S_DECODE: begin
                case (r_item.operation)
                    OP_ARRIVE: begin
                        if (!r_active[r_item.task_id] && !full0) begin
                            q_we    = 1'b1;
                            q_waddr = qaddr('0, tail_of(r_heads[0], r_counts[0]));
                            q_wdata = r_item.task_id;
                            t_we    = 1'b1;
                            t_waddr = r_item.task_id;
                            t_wdata = '{total: r_item.task_length, done_time: 16'd0,
                                        io_percent: r_item.io_percent, level: 2'd0,
                                        slice_left: r_slice, run_limit: r_quantum};
                        end
                        n_state = S_OUT;
                    end
                    OP_DISPATCH: begin
                        q_raddr = qaddr(first_lv, r_heads[first_lv]);
                        n_state = any_q ? S_QREAD : S_OUT;
                    end
                    OP_BOOST: begin
                        q_raddr = qaddr(blv_next, r_heads[blv_next]);
                        n_state = (bmore && !full0) ? S_BQREAD : S_OUT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_QREAD: begin
                t_raddr = r_qrd;
                n_state = S_TREAD;
            end
            S_TREAD: n_state = S_CALC;
            S_CALC: begin
                t_we    = 1'b1;
                t_waddr = r_id;
                t_wdata = r_trd;
                t_wdata.done_time  = r_trd.done_time + run16;
                t_wdata.slice_left = slice_new;
                if (!complete) begin
                    if (slice_new == '0) begin
                        t_wdata.slice_left = r_slice;
                        t_wdata.run_limit  = r_quantum;
                    end else begin
                        t_wdata.run_limit = (slice_new < {8'd0, r_quantum}) ?
                                            slice_new[7:0] : r_quantum;
                    end
                    t_wdata.level = 2'(tgt);
                    // Head and count already reflect the pop, so the tail is current.
                    q_we    = 1'b1;
                    q_waddr = qaddr(tgt, tail_of(r_heads[tgt], r_counts[tgt]));
                    q_wdata = r_id;
                end
                n_state = S_OUT;
            end
            S_BQREAD: begin
                t_raddr = r_qrd;
                n_state = S_BTWAIT;
            end
            S_BTWAIT: n_state = S_BMOVE;
            S_BMOVE: begin
                t_we    = 1'b1;
                t_waddr = r_id;
                t_wdata = r_trd;
                t_wdata.level      = 2'd0;
                t_wdata.slice_left = r_slice;
                t_wdata.run_limit  = r_quantum;
                q_we    = 1'b1;
                q_waddr = qaddr('0, tail_of(r_heads[0], r_counts[0]));
                q_wdata = r_id;
                n_state = S_DECODE;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heads     <= '0;
            r_counts    <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_DECODE: begin
                    if (r_item.operation == OP_ARRIVE) begin
                        if (!r_active[r_item.task_id] && !full0) begin
                            r_active[r_item.task_id] <= 1'b1;
                            r_counts[0] <= r_counts[0] + 1'b1;
                        end
                    end else if (r_item.operation == OP_DISPATCH && any_q) begin
                        r_heads[first_lv]  <= inc_ix(r_heads[first_lv]);
                        r_counts[first_lv] <= r_counts[first_lv] - 1'b1;
                    end else if (r_item.operation == OP_BOOST && bmore && !full0) begin
                        r_heads[blv_next]  <= inc_ix(r_heads[blv_next]);
                        r_counts[blv_next] <= r_counts[blv_next] - 1'b1;
                    end
                end
                S_CALC: begin
                    if (complete) r_active[r_id] <= 1'b0;
                    else          r_counts[tgt] <= r_counts[tgt] + 1'b1;
                end
                S_BMOVE: r_counts[0] <= r_counts[0] + 1'b1;
                S_OUT:   r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_item <= i_in_item;
        case (r_state)
            S_DECODE: begin
                r_lv  <= first_lv;
                r_res <= '0;
                case (r_item.operation)
                    OP_ARRIVE: begin
                        r_res.out_task_id <= r_item.task_id;
                        r_res.status <= (!r_active[r_item.task_id] && !full0) ?
                                        ST_QUEUED : ST_REJECTED;
                    end
                    OP_DISPATCH: r_res.status <= ST_IDLE;
                    default:     r_res.status <= ST_BOOSTED;
                endcase
            end
            S_QREAD, S_BQREAD: r_id <= r_qrd;
            S_CALC: begin
                r_res.status      <= complete ? ST_DONE : ST_RAN;
                r_res.out_task_id <= r_id;
                r_res.run_amount  <= run16[7:0];
                r_res.new_level   <= complete ? 2'(r_lv) : 2'(tgt);
            end
            default: ;
        endcase
    end

    // Result register never overwritten while a result waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_out_valid)
        else $error("result overwrite check");
    // A new transfer is only taken from the idle state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (r_state == S_IDLE))
        else $error("transfer taken while busy");
    // Level 0 never exceeds its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counts[0] <= CW'(QUEUE_DEPTH))
        else $error("level 0 overflow");
    // Boost moves only while level 0 has room.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BMOVE) |-> !full0)
        else $error("boost into full level 0");

endmodule
